FILE: hw/rtl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants of the 3x3 matrix inverse: default widths, the pipeline
// depth of the cofactor front end and the cofactor index tables.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FRONT_STAGES   = 5;
    localparam int NUM_ELEM       = 9;

    // adj[i] = +/- (m[A]*m[B] - m[C]*m[D])
    localparam int COF_A [NUM_ELEM] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
    localparam int COF_B [NUM_ELEM] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
    localparam int COF_C [NUM_ELEM] = '{7, 7, 2, 6, 6, 3, 6, 6, 1};
    localparam int COF_D [NUM_ELEM] = '{5, 2, 4, 5, 2, 2, 4, 1, 3};
    localparam logic [NUM_ELEM-1:0] COF_NEG = 9'b0_1010_1010;

    // adjugate entries that pair with m00, m01, m02 in the determinant
    localparam int DET_ADJ [3] = '{0, 3, 6};

endpackage

FILE: hw/rtl/m3i_if.sv
// ----------------------------------------------------------------------------
// m3i_if
// Valid/ready channels of the matrix inverse: the input matrix and the
// inverse with its determinant.
// ----------------------------------------------------------------------------
interface m3i_mat_if
    import m3i_pkg::*;
#(
    parameter int DW = DATA_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

interface m3i_inv_if
    import m3i_pkg::*;
#(
    parameter int DW = DATA_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [DW-1:0] det_value;
    logic                 singular;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    det_value, singular, input ready);
    modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    det_value, singular, output ready);
endinterface

FILE: hw/rtl/m3i_front.sv
// ----------------------------------------------------------------------------
// m3i_front
// Cofactor and determinant pipeline: products, adjugate, split determinant
// products, recombination and the final determinant sum.
// ----------------------------------------------------------------------------
module m3i_front
    import m3i_pkg::*;
#(
    parameter  int DW   = DATA_WIDTH_DEF,
    localparam int CW   = 2 * DW + 1,
    localparam int DETW = 3 * DW + 3
)
(
    input  logic                   clk,
    input  logic [FRONT_STAGES-1:0] en,
    input  logic signed [DW-1:0]   m   [NUM_ELEM],
    output logic signed [CW-1:0]   adj [NUM_ELEM],
    output logic signed [DETW-1:0] det
);

    localparam int PW = 2 * DW;
    localparam int HW = 2 * DW + 1;

    logic signed [PW-1:0]   pa_reg   [NUM_ELEM];
    logic signed [PW-1:0]   pb_reg   [NUM_ELEM];
    logic signed [DW-1:0]   mr0_reg  [3];
    logic signed [DW-1:0]   mr1_reg  [3];
    logic signed [CW-1:0]   adj1_reg [NUM_ELEM];
    logic signed [CW-1:0]   adj2_reg [NUM_ELEM];
    logic signed [CW-1:0]   adj3_reg [NUM_ELEM];
    logic signed [CW-1:0]   adj4_reg [NUM_ELEM];
    logic signed [HW-1:0]   lo_reg   [3];
    logic signed [HW-1:0]   hi_reg   [3];
    logic signed [DETW-1:0] prod_reg [3];
    logic signed [DETW-1:0] det_reg;
    logic signed [CW-1:0]   diff     [NUM_ELEM];

    always_comb
    begin
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            diff[i] = CW'(pa_reg[i]) - CW'(pb_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < NUM_ELEM; i++)
            begin
                pa_reg[i] <= m[COF_A[i]] * m[COF_B[i]];
                pb_reg[i] <= m[COF_C[i]] * m[COF_D[i]];
            end
            for (int j = 0; j < 3; j++)
            begin
                mr0_reg[j] <= m[j];
            end
        end
        if (en[1])
        begin
            for (int i = 0; i < NUM_ELEM; i++)
            begin
                adj1_reg[i] <= COF_NEG[i] ? -diff[i] : diff[i];
            end
            mr1_reg <= mr0_reg;
        end
        if (en[2])
        begin
            for (int j = 0; j < 3; j++)
            begin
                lo_reg[j] <= HW'(mr1_reg[j])
                           * $signed({1'b0, adj1_reg[DET_ADJ[j]][DW-1:0]});
                hi_reg[j] <= HW'(mr1_reg[j])
                           * HW'($signed(adj1_reg[DET_ADJ[j]][CW-1:DW]));
            end
            adj2_reg <= adj1_reg;
        end
        if (en[3])
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_reg[j] <= (DETW'(hi_reg[j]) <<< DW) + DETW'(lo_reg[j]);
            end
            adj3_reg <= adj2_reg;
        end
        if (en[4])
        begin
            det_reg  <= prod_reg[0] + prod_reg[1] + prod_reg[2];
            adj4_reg <= adj3_reg;
        end
    end

    assign adj = adj4_reg;
    assign det = det_reg;

endmodule

FILE: hw/rtl/m3i_div_lane.sv
// ----------------------------------------------------------------------------
// m3i_div_lane
// One inverse element: magnitudes, overflow check, one quotient bit per
// stage of restoring division, then sign and saturation.
// ----------------------------------------------------------------------------
module m3i_div_lane
    import m3i_pkg::*;
#(
    parameter  int DW   = DATA_WIDTH_DEF,
    parameter  int FB   = FRAC_BITS_DEF,
    localparam int CW   = 2 * DW + 1,
    localparam int DETW = 3 * DW + 3,
    localparam int LS   = DW + 3
)
(
    input  logic                   clk,
    input  logic [LS-1:0]          en,
    input  logic signed [CW-1:0]   adj,
    input  logic signed [DETW-1:0] det,
    output logic signed [DW-1:0]   q
);

    localparam int NW = CW + 2 * FB;
    localparam int RW = (NW > DETW + DW) ? NW : DETW + DW;

    logic [NW-1:0]   na_reg;
    logic [DETW-1:0] da_reg;
    logic            neg0_reg;
    logic [RW-1:0]   rem_reg  [DW];
    logic [DETW-1:0] d_reg    [DW];
    logic [DW-1:0]   quo_reg  [DW+1];
    logic            neg_reg  [DW+1];
    logic            big_reg  [DW+1];
    logic [DW-1:0]   q_reg;
    logic [CW-1:0]   adj_abs;
    logic [DW-1:0]   lim;
    logic [DW-1:0]   mag;

    assign adj_abs = adj[CW-1] ? CW'(-adj) : CW'(adj);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            na_reg   <= {adj_abs, {(2 * FB){1'b0}}};
            da_reg   <= det[DETW-1] ? DETW'(-det) : DETW'(det);
            neg0_reg <= adj[CW-1] ^ det[DETW-1];
        end
        if (en[1])
        begin
            rem_reg[0] <= RW'(na_reg);
            d_reg[0]   <= da_reg;
            quo_reg[0] <= '0;
            neg_reg[0] <= neg0_reg;
            big_reg[0] <= RW'(na_reg) >= (RW'(da_reg) << DW);
        end
    end

    for (genvar t = 0; t < DW; t++)
    begin : g_step
        localparam int B = DW - 1 - t;
        logic [RW-1:0] sh;
        logic          ge;

        assign sh = RW'(d_reg[t]) << B;
        assign ge = rem_reg[t] >= sh;

        always_ff @(posedge clk)
        begin
            if (en[2 + t])
            begin
                quo_reg[t+1] <= quo_reg[t] | (DW'(ge) << B);
                neg_reg[t+1] <= neg_reg[t];
                big_reg[t+1] <= big_reg[t];
            end
        end

        if (t < DW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en[2 + t])
                begin
                    rem_reg[t+1] <= ge ? rem_reg[t] - sh : rem_reg[t];
                    d_reg[t+1]   <= d_reg[t];
                end
            end
        end
    end

    assign lim = neg_reg[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    assign mag = (big_reg[DW] || quo_reg[DW] > lim) ? lim : quo_reg[DW];

    always_ff @(posedge clk)
    begin
        if (en[LS-1])
        begin
            q_reg <= neg_reg[DW] ? DW'(-mag) : mag;
        end
    end

    assign q = $signed(q_reg);

endmodule

FILE: hw/rtl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 fixed-point matrix inverse by the adjugate: cofactor front end, nine
// parallel divider lanes and a merge that applies the singular case.
//
//   channel  | dir | payload
//   ---------+-----+------------------------------------------------
//   matrix   | in  | m00..m22, signed Q(W-F).F
//   inverse  | out | r00..r22, det_value (saturated), singular
//
// One item per cycle while inverse.ready does not stall the output; the depth
// is set by the one quotient bit per stage of the divider lanes.
// Reset clears only the stage valid bits.
// Each stage advances when it is empty or its successor advances, so
// bubbles collapse and items enter while a finished result waits.
// ----------------------------------------------------------------------------
module matrix3x3_inverse
    import m3i_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    m3i_mat_if.sink    matrix,
    m3i_inv_if.source  inverse
);

    localparam int DW   = DATA_WIDTH;
    localparam int CW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;
    localparam int LS   = DW + 3;
    localparam int NS   = FRONT_STAGES + LS;

    typedef struct packed {
        logic          singular;
        logic [DW-1:0] value;
    } det_info_t;

    logic [NS-1:0]         v_reg;
    logic [NS-1:0]         en;
    logic signed [DW-1:0]  m   [NUM_ELEM];
    logic signed [CW-1:0]  adj [NUM_ELEM];
    logic signed [DW-1:0]  q   [NUM_ELEM];
    logic signed [DETW-1:0] det;

    logic [DETW-1:0] dabs_reg;
    logic            dneg_reg;
    logic            dzero_reg;
    det_info_t       dinfo_reg [LS-1];
    logic [DETW-1:0] dshift;
    logic [DW-1:0]   dlim;
    logic [DW-1:0]   dmag;

    assign m[0] = matrix.m00;
    assign m[1] = matrix.m01;
    assign m[2] = matrix.m02;
    assign m[3] = matrix.m10;
    assign m[4] = matrix.m11;
    assign m[5] = matrix.m12;
    assign m[6] = matrix.m20;
    assign m[7] = matrix.m21;
    assign m[8] = matrix.m22;

    // handshake and stage advance
    assign en[NS-1] = !v_reg[NS-1] || inverse.ready;
    for (genvar s = 0; s < NS - 1; s++)
    begin : g_en
        assign en[s] = !v_reg[s] || en[s+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < NS; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= (s == 0) ? matrix.valid : v_reg[(s == 0) ? 0 : s - 1];
                end
            end
        end
    end

    assign matrix.ready  = en[0];
    assign inverse.valid = v_reg[NS-1];

    m3i_front #(.DW(DW)) u_front
    (
        .clk (clk),
        .en  (en[FRONT_STAGES-1:0]),
        .m   (m),
        .adj (adj),
        .det (det)
    );

    for (genvar i = 0; i < NUM_ELEM; i++)
    begin : g_lane
        m3i_div_lane #(.DW(DW), .FB(FRAC_BITS)) u_lane
        (
            .clk (clk),
            .en  (en[NS-1:FRONT_STAGES]),
            .adj (adj[i]),
            .det (det),
            .q   (q[i])
        );
    end

    // determinant output path, alongside the lanes
    assign dshift = dabs_reg >> (2 * FRAC_BITS);
    assign dlim   = dneg_reg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    assign dmag   = (dshift > DETW'(dlim)) ? dlim : dshift[DW-1:0];

    always_ff @(posedge clk)
    begin
        if (en[FRONT_STAGES])
        begin
            dabs_reg  <= det[DETW-1] ? DETW'(-det) : DETW'(det);
            dneg_reg  <= det[DETW-1];
            dzero_reg <= (det == '0);
        end
        if (en[FRONT_STAGES + 1])
        begin
            dinfo_reg[0].singular <= dzero_reg;
            dinfo_reg[0].value    <= dneg_reg ? DW'(-dmag) : dmag;
        end
    end

    for (genvar k = 1; k < LS - 1; k++)
    begin : g_dpipe
        always_ff @(posedge clk)
        begin
            if (en[FRONT_STAGES + 1 + k])
            begin
                dinfo_reg[k] <= dinfo_reg[k-1];
            end
        end
    end

    // merge lanes; a singular matrix gives all-zero elements and det_value
    assign inverse.singular  = dinfo_reg[LS-2].singular;
    assign inverse.det_value = dinfo_reg[LS-2].singular ? '0 : $signed(dinfo_reg[LS-2].value);
    assign inverse.r00 = dinfo_reg[LS-2].singular ? '0 : q[0];
    assign inverse.r01 = dinfo_reg[LS-2].singular ? '0 : q[1];
    assign inverse.r02 = dinfo_reg[LS-2].singular ? '0 : q[2];
    assign inverse.r10 = dinfo_reg[LS-2].singular ? '0 : q[3];
    assign inverse.r11 = dinfo_reg[LS-2].singular ? '0 : q[4];
    assign inverse.r12 = dinfo_reg[LS-2].singular ? '0 : q[5];
    assign inverse.r20 = dinfo_reg[LS-2].singular ? '0 : q[6];
    assign inverse.r21 = dinfo_reg[LS-2].singular ? '0 : q[7];
    assign inverse.r22 = dinfo_reg[LS-2].singular ? '0 : q[8];

endmodule
